// ===== rtl/ordered_list_insert_delete_defines.svh =====
// Assertion macros used by the ordered list top level.
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define OLID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define OLID_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/olid_pkg.sv =====
// Types and constants shared by the ordered list modules.
package olid_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  // cell index width for the deepest supported list (64 entries)
  localparam int unsigned IDX_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OUT_CNT_W = 5;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_DEL_MID   = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_DUMP      = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_SHR  = 3'd1,  // every cell takes its left neighbor
    CELL_SHL  = 3'd2,  // cells at or past idx take their right neighbor
    CELL_LOAD = 3'd3,  // cell idx takes data
    CELL_ROT  = 3'd4   // cells below idx shift left, cell idx takes data
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [VAL_W-1:0] value;
    logic [4:0]              position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic [OUT_CNT_W-1:0]    element_count;
    logic                    is_empty;
    logic signed [VAL_W-1:0] element_value;
    logic                    last;
  } out_item_t;

endpackage

// ===== rtl/olid_cell.sv =====
// One storage cell of the list chain.
module olid_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                           clk_i,
  input  olid_pkg::cell_ctrl_t           ctrl_i,
  input  logic [olid_pkg::VAL_W-1:0]     left_i,
  input  logic [olid_pkg::VAL_W-1:0]     right_i,
  output logic [olid_pkg::VAL_W-1:0]     data_o
);

  localparam logic [olid_pkg::IDX_W-1:0] MY_IDX = olid_pkg::IDX_W'(CELL_IDX);

  logic [olid_pkg::VAL_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      olid_pkg::CELL_HOLD: data_d = data_q;
      olid_pkg::CELL_SHR:  data_d = left_i;
      olid_pkg::CELL_SHL: begin
        if (MY_IDX >= ctrl_i.idx) data_d = right_i;
      end
      olid_pkg::CELL_LOAD: begin
        if (MY_IDX == ctrl_i.idx) data_d = ctrl_i.data;
      end
      olid_pkg::CELL_ROT: begin
        if (MY_IDX < ctrl_i.idx) data_d = right_i;
        else if (MY_IDX == ctrl_i.idx) data_d = ctrl_i.data;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/olid_chain.sv =====
// Row of list cells with front tap and back select.
module olid_chain #(
  parameter int unsigned LIST_DEPTH = olid_pkg::LIST_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  olid_pkg::cell_ctrl_t                ctrl_i,
  input  logic [$clog2(LIST_DEPTH)-1:0]       back_idx_i,
  output logic [olid_pkg::VAL_W-1:0]          front_o,
  output logic [olid_pkg::VAL_W-1:0]          back_o
);

  logic [olid_pkg::VAL_W-1:0] cell_data [LIST_DEPTH];

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [olid_pkg::VAL_W-1:0] left_in, right_in;

    // head takes the new value on a front insert; tail pulls in zero
    if (g == 0) begin : g_head
      assign left_in = ctrl_i.data;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    olid_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .left_i (left_in),
      .right_i(right_in),
      .data_o (cell_data[g])
    );
  end

  assign front_o = cell_data[0];
  assign back_o  = cell_data[back_idx_i];

endmodule

// ===== rtl/ordered_list_insert_delete.sv =====
// Top level of the bounded ordered list with insert, remove and dump commands.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | in_item_i  (olid_pkg::in_item_t)
//  out     | output    | out_valid_o/ out_ready_i| out_item_o (olid_pkg::out_item_t)
//
//  Insert and remove commands update the list at the accept edge; the
//  response is registered from S_RESP once the output stage is free.
//  A dump of n elements emits n transactions; the chain rotates one cell per
//  emitted transaction, one element per cycle while the output stage is free.
//  One command is in flight at a time; out_ready_i low stalls the response
//  stage and with it the next accept.
//  Reset clears the element count, the control state and the output valid;
//  cell contents are not reset and are only read below the count.
`include "ordered_list_insert_delete_defines.svh"

module ordered_list_insert_delete #(
  parameter int unsigned LIST_DEPTH = olid_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  olid_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output olid_pkg::out_item_t out_item_o
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned LOC_W = $clog2(LIST_DEPTH);
  // common width for comparing the 5-bit position with the count
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RESP = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e                     state_d, state_q;
  logic [CNT_W-1:0]           count_d, count_q;
  logic [CNT_W-1:0]           dump_left_d, dump_left_q;
  olid_pkg::status_e          status_d, status_q;
  logic [olid_pkg::VAL_W-1:0] snap_front_q, snap_back_q;
  logic                       snap_load;
  logic                       out_valid_q;
  olid_pkg::out_item_t        out_d, out_q;
  logic                       out_load;

  olid_pkg::cell_ctrl_t       cell_ctrl;
  logic [olid_pkg::VAL_W-1:0] chain_front, chain_back;

  olid_pkg::cmd_e             cmd;
  logic                       in_acc;
  logic                       out_free;
  logic                       list_empty, list_full;
  logic [CMP_W-1:0]           pos_c, cnt_c;
  logic                       pos_bad;
  logic [LOC_W-1:0]           pos_loc, mid_loc, last_loc, cnt_loc;
  logic                       dump_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cmd        = olid_pkg::cmd_e'(in_item_i.command);

  assign list_empty = (count_q == '0);
  assign list_full  = (count_q == CNT_W'(LIST_DEPTH));

  // position is 1-based; zero or past the count is rejected
  assign pos_c   = CMP_W'(in_item_i.position);
  assign cnt_c   = CMP_W'(count_q);
  assign pos_bad = (pos_c == '0) || (pos_c > cnt_c);
  assign pos_loc = LOC_W'(pos_c - CMP_W'(1));
  assign mid_loc = LOC_W'(count_q >> 1);
  assign last_loc = LOC_W'(count_q - CNT_W'(1));
  assign cnt_loc  = LOC_W'(count_q);
  assign dump_last = (dump_left_q == CNT_W'(1));

  olid_chain #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (cell_ctrl),
    .back_idx_i(last_loc),
    .front_o   (chain_front),
    .back_o    (chain_back)
  );

  // Command decode and sequencing. Insert and remove commands update the
  // chain at the accept edge; a dump rotates the chain once per emitted
  // element so the original order is back after the last one.
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    dump_left_d    = dump_left_q;
    status_d       = status_q;
    snap_load      = 1'b0;
    out_load       = 1'b0;
    out_d          = out_q;
    cell_ctrl.op   = olid_pkg::CELL_HOLD;
    cell_ctrl.idx  = '0;
    cell_ctrl.data = in_item_i.value;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d = olid_pkg::ST_OK;
          state_d  = S_RESP;
          case (cmd)
            olid_pkg::CMD_INS_FRONT: begin
              if (list_full) begin
                status_d = olid_pkg::ST_FULL;
              end else begin
                cell_ctrl.op = olid_pkg::CELL_SHR;
                count_d      = count_q + CNT_W'(1);
              end
            end
            olid_pkg::CMD_INS_BACK: begin
              if (list_full) begin
                status_d = olid_pkg::ST_FULL;
              end else begin
                cell_ctrl.op  = olid_pkg::CELL_LOAD;
                cell_ctrl.idx = olid_pkg::IDX_W'(cnt_loc);
                count_d       = count_q + CNT_W'(1);
              end
            end
            olid_pkg::CMD_DEL_FRONT: begin
              if (list_empty) begin
                status_d = olid_pkg::ST_EMPTY;
              end else begin
                cell_ctrl.op = olid_pkg::CELL_SHL;
                count_d      = count_q - CNT_W'(1);
              end
            end
            olid_pkg::CMD_DEL_BACK: begin
              if (list_empty) status_d = olid_pkg::ST_EMPTY;
              else count_d = count_q - CNT_W'(1);
            end
            olid_pkg::CMD_DEL_MID: begin
              if (list_empty) begin
                status_d = olid_pkg::ST_EMPTY;
              end else begin
                cell_ctrl.op  = olid_pkg::CELL_SHL;
                cell_ctrl.idx = olid_pkg::IDX_W'(mid_loc);
                count_d       = count_q - CNT_W'(1);
              end
            end
            olid_pkg::CMD_DEL_POS: begin
              if (list_empty) begin
                status_d = olid_pkg::ST_EMPTY;
              end else if (pos_bad) begin
                status_d = olid_pkg::ST_BADPOS;
              end else begin
                cell_ctrl.op  = olid_pkg::CELL_SHL;
                cell_ctrl.idx = olid_pkg::IDX_W'(pos_loc);
                count_d       = count_q - CNT_W'(1);
              end
            end
            olid_pkg::CMD_DUMP: begin
              if (list_empty) begin
                status_d = olid_pkg::ST_EMPTY;
              end else begin
                // front and back stay fixed in the results while cells rotate
                snap_load   = 1'b1;
                dump_left_d = count_q;
                state_d     = S_DUMP;
              end
            end
            olid_pkg::CMD_NOP: status_d = olid_pkg::ST_OK;
            default:           status_d = olid_pkg::ST_OK;
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_d.status            = status_q;
          out_d.front_value       = list_empty ? '0 : chain_front;
          out_d.back_value        = list_empty ? '0 : chain_back;
          out_d.element_count     = olid_pkg::OUT_CNT_W'(count_q);
          out_d.is_empty          = list_empty;
          out_d.element_value     = '0;
          out_d.last              = 1'b1;
          state_d                 = S_IDLE;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_d.status        = olid_pkg::ST_OK;
          out_d.front_value   = snap_front_q;
          out_d.back_value    = snap_back_q;
          out_d.element_count = olid_pkg::OUT_CNT_W'(count_q);
          out_d.is_empty      = 1'b0;
          out_d.element_value = chain_front;
          out_d.last          = dump_last;
          // head wraps to the back of the stored range
          cell_ctrl.op        = olid_pkg::CELL_ROT;
          cell_ctrl.idx       = olid_pkg::IDX_W'(last_loc);
          cell_ctrl.data      = chain_front;
          dump_left_d         = dump_left_q - CNT_W'(1);
          if (dump_last) state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dump_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_left_q <= dump_left_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (snap_load) begin
      snap_front_q <= chain_front;
      snap_back_q  <= chain_back;
    end
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `OLID_NEVER(a_count_max, count_q > CNT_W'(LIST_DEPTH), "element count above list depth")
  `OLID_ASSERT(a_count_hold, !in_acc |=> $stable(count_q), "count changed without a transaction")
  `OLID_ASSERT(a_dump_left, state_q == S_DUMP |-> (dump_left_q != '0 && dump_left_q <= count_q), "dump counter out of range")
  `OLID_ASSERT(a_dump_end, (state_q == S_DUMP && out_load && dump_last) |=> state_q == S_IDLE, "dump did not finish on last element")

endmodule
